// ===== hdl/bscfn_pkg.sv =====
`default_nettype none
package bscfn_pkg;

    localparam int MAP_BITS   = 256;
    localparam int ACTION_W   = 3;
    localparam int INDEX_W    = 9;
    localparam int CFG_W      = 9;
    localparam int FOUND_W    = 8;
    localparam int CFG_RESET  = 256;
    localparam int WORD_W     = (MAP_BITS < 32) ? MAP_BITS : 32;
    localparam int NUM_WORDS  = MAP_BITS / WORD_W;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_IDX_W  = $clog2(MAP_BITS);
    localparam int POS_W      = (BIT_IDX_W + 1 > CFG_W) ? BIT_IDX_W + 1 : CFG_W;

    localparam logic [ACTION_W-1:0] ACT_GET        = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SET        = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_NEXT_SET   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_NEXT_CLEAR = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_ALL  = 3'd5;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_search;
        logic is_clear_all;
        logic hit;
        logic last;
    } t_sts;

endpackage
`default_nettype wire

// ===== hdl/bscfn_datapath.sv =====
`default_nettype none
module bscfn_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bscfn_pkg::t_cmd                 i_cmd,
    output bscfn_pkg::t_sts                      o_sts,
    input  wire logic                            i_cfg_valid,
    input  wire logic [bscfn_pkg::CFG_W-1:0]     i_cfg_bits_in_use,
    input  wire logic [bscfn_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [bscfn_pkg::INDEX_W-1:0]   i_bit_index,
    output logic                                 o_bit_value,
    output logic                                 o_found,
    output logic [bscfn_pkg::FOUND_W-1:0]        o_found_index
);
    import bscfn_pkg::*;

    logic [CFG_W-1:0]      r_cfg;
    t_word                 r_mem [NUM_WORDS];
    logic [ACTION_W-1:0]   r_action;
    logic [POS_W-1:0]      r_idx;
    logic [POS_W-1:0]      r_lim;
    logic [WORD_IDX_W-1:0] r_word;
    logic                  r_value;
    logic                  r_found;
    logic [FOUND_W-1:0]    r_pos;
    logic                  r_o_value;
    logic                  r_o_found;
    logic [FOUND_W-1:0]    r_o_pos;

    logic [POS_W-1:0]      cfg_ext;
    logic [POS_W-1:0]      n_lim;
    logic [POS_W-1:0]      in_idx_ext;
    logic [WORD_IDX_W-1:0] n_word;
    logic                  in_range;
    logic [WORD_IDX_W-1:0] acc_word;
    logic [BIT_W-1:0]      acc_bit;
    t_word                 acc_data;
    t_word                 cur_word;
    logic [POS_W-1:0]      word_base;
    logic [POS_W-1:0]      next_base;
    t_word                 in_lim;
    t_word                 cand;
    logic                  want;
    logic                  hit;
    logic [BIT_W-1:0]      hit_bit;
    logic [POS_W-1:0]      hit_pos;
    logic                  is_search;
    logic                  is_clear_all;
    logic                  last;

    always_comb begin
        cfg_ext    = POS_W'(r_cfg);
        n_lim      = (cfg_ext > POS_W'(MAP_BITS)) ? POS_W'(MAP_BITS) : cfg_ext;
        in_idx_ext = POS_W'(i_bit_index);
        n_word     = (i_action == ACT_CLEAR_ALL) ? '0 : in_idx_ext[BIT_W +: WORD_IDX_W];
        in_range   = r_idx < r_lim;
        acc_word   = r_idx[BIT_W +: WORD_IDX_W];
        acc_bit    = r_idx[BIT_W-1:0];
        acc_data   = r_mem[acc_word];
        cur_word   = r_mem[r_word];
        word_base  = POS_W'(r_word) << BIT_W;
        next_base  = word_base + POS_W'(WORD_W);
        want       = (r_action == ACT_NEXT_SET);
        for (int b = 0; b < WORD_W; b++) begin
            in_lim[b] = (word_base + POS_W'(b)) < r_lim;
            cand[b]   = in_lim[b] && ((word_base + POS_W'(b)) >= r_idx)
                        && (cur_word[b] == want);
        end
        hit     = |cand;
        hit_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                hit_bit = BIT_W'(b);
            end
        end
        hit_pos      = word_base + POS_W'(hit_bit);
        is_search    = (r_action == ACT_NEXT_SET) || (r_action == ACT_NEXT_CLEAR);
        is_clear_all = (r_action == ACT_CLEAR_ALL);
        last         = (r_word == WORD_IDX_W'(NUM_WORDS - 1)) || (next_base >= r_lim);
    end

    assign o_sts.is_search    = is_search;
    assign o_sts.is_clear_all = is_clear_all;
    assign o_sts.hit          = hit;
    assign o_sts.last         = last || (is_search && !in_range);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_W'(CFG_RESET);
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_bits_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_WORDS; w++) begin
                r_mem[w] <= '0;
            end
        end else if (i_cmd.step) begin
            unique case (r_action)
                ACT_SET: begin
                    if (in_range) begin
                        r_mem[acc_word][acc_bit] <= 1'b1;
                    end
                end
                ACT_CLEAR: begin
                    if (in_range) begin
                        r_mem[acc_word][acc_bit] <= 1'b0;
                    end
                end
                ACT_CLEAR_ALL: begin
                    r_mem[r_word] <= cur_word & ~in_lim;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_idx    <= in_idx_ext;
            r_lim    <= n_lim;
            r_word   <= n_word;
            r_value  <= 1'b0;
            r_found  <= 1'b0;
            r_pos    <= '0;
        end else if (i_cmd.step) begin
            unique case (r_action)
                ACT_GET: begin
                    r_value <= in_range && acc_data[acc_bit];
                end
                ACT_NEXT_SET, ACT_NEXT_CLEAR: begin
                    if (hit) begin
                        r_found <= 1'b1;
                        r_pos   <= hit_pos[FOUND_W-1:0];
                    end else if (!last) begin
                        r_word <= r_word + 1'b1;
                    end
                end
                ACT_CLEAR_ALL: begin
                    if (!last) begin
                        r_word <= r_word + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.emit) begin
            r_o_value <= r_value;
            r_o_found <= r_found;
            r_o_pos   <= r_pos;
        end
    end

    assign o_bit_value   = r_o_value;
    assign o_found       = r_o_found;
    assign o_found_index = r_o_pos;

endmodule
`default_nettype wire

// ===== hdl/bscfn_ctrl.sv =====
`default_nettype none
module bscfn_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output bscfn_pkg::t_cmd      o_cmd,
    input  wire bscfn_pkg::t_sts i_sts
);
    import bscfn_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   done;

    always_comb begin
        out_free = !r_out_valid || i_ready;
        if (i_sts.is_search) begin
            done = i_sts.hit || i_sts.last;
        end else if (i_sts.is_clear_all) begin
            done = i_sts.last;
        end else begin
            done = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_EXEC: begin
                o_cmd.step = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = out_free;
            end
            default: begin
            end
        endcase
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_ready))
        else $error("result emitted over an untaken item");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    a_done_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && done) |=> (r_state == S_EMIT))
        else $error("finished item did not reach emit");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_out_valid)
        else $error("emitted result not presented");

endmodule
`default_nettype wire

// ===== hdl/bitmap_set_clear_find_next_top.sv =====
`default_nettype none
// Bit map of 256 bits, cleared at reset, with get, set, clear, next-set search, next-clear
// search and clear-all actions, each item giving one result. Get, set and clear finish in
// a single step of the store; a search or clear-all scans the store one 32-bit word per
// cycle, stopping when a search hits, so it takes longer the more words it visits. One
// item is worked on at a time, and the next item is accepted while a finished result
// still waits in the output register; a result that is not taken holds the block until
// it is.
module bitmap_set_clear_find_next_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [bscfn_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [bscfn_pkg::INDEX_W-1:0]   i_bit_index,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_bit_value,
    output logic                                 o_found,
    output logic [bscfn_pkg::FOUND_W-1:0]        o_found_index,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [bscfn_pkg::CFG_W-1:0]     i_cfg_bits_in_use
);
    import bscfn_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bscfn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    bscfn_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_bits_in_use (i_cfg_bits_in_use),
        .i_action          (i_action),
        .i_bit_index       (i_bit_index),
        .o_bit_value       (o_bit_value),
        .o_found           (o_found),
        .o_found_index     (o_found_index)
    );

endmodule
`default_nettype wire
